// ===== src/fsr_pkg.sv =====
// Shared types and constants for the frame buffer shape rasterizer.
package fsr_pkg;

  typedef enum logic [2:0] {
    K_CLEAR  = 3'd0,
    K_POINT  = 3'd1,
    K_CIRCLE = 3'd2,
    K_DISC   = 3'd3,
    K_RECT   = 3'd4,
    K_BOX    = 3'd5,
    K_LINE   = 3'd6,
    K_READ   = 3'd7
  } kind_t;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;
  localparam logic [7:0] SPACE      = 8'd32;

  typedef struct packed {
    kind_t              kind;
    logic signed [7:0]  r1;
    logic signed [7:0]  c1;
    logic signed [7:0]  r2;
    logic signed [7:0]  c2;
    logic signed [7:0]  rlo;
    logic signed [7:0]  rhi;
    logic signed [7:0]  clo;
    logic signed [7:0]  chi;
    logic [7:0]         glyph;
    logic [15:0]        r1sq;
    logic [15:0]        c1sq;
    logic [16:0]        hi;
    logic [15:0]        lo;
    logic               rad_zero;
    logic [7:0]         dd;
    logic signed [8:0]  ee;
    logic signed [20:0] n0;
  } cmd_t;

endpackage

// ===== src/fsr_ram.sv =====
// Generic single write port RAM with registered read.
module fsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/fsr_front.sv =====
// Front end: accepts items, precomputes shape terms and queues commands.
module fsr_front import fsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        kind,
  input  logic signed [7:0] first_row,
  input  logic signed [7:0] first_col,
  input  logic signed [7:0] second_row,
  input  logic signed [7:0] second_col,
  input  logic [7:0]        radius,
  input  logic [7:0]        glyph,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_take
);
  logic              a_valid;
  kind_t             a_kind;
  logic signed [7:0] a_r1, a_c1, a_r2, a_c2;
  logic [7:0]        a_rad, a_glyph, a_dd;
  logic [15:0]       a_r1sq, a_c1sq, a_radsq;
  logic signed [16:0] a_c1dd, a_r1ee;
  logic signed [8:0] a_ee;

  logic signed [8:0] dr, dc, dd_s, ee;
  logic signed [15:0] r1sq_s, c1sq_s;
  logic              accept, move;
  cmd_t              b_cmd;

  cmd_t       q_mem [2];
  logic       q_wp, q_rp;
  logic [1:0] q_cnt;

  assign dr   = 9'(second_row) - 9'(first_row);
  assign dc   = 9'(second_col) - 9'(first_col);
  assign dd_s = dr < 0 ? -dr : dr;
  assign ee   = dr < 0 ? -dc : dc;
  assign r1sq_s = 16'(first_row) * 16'(first_row);
  assign c1sq_s = 16'(first_col) * 16'(first_col);

  assign full   = a_valid && q_cnt == 2'd2;
  assign accept = push && !full;
  assign move   = a_valid && q_cnt != 2'd2;

  always_comb begin
    b_cmd.kind     = a_kind;
    b_cmd.r1       = a_r1;
    b_cmd.c1       = a_c1;
    b_cmd.r2       = a_r2;
    b_cmd.c2       = a_c2;
    b_cmd.rlo      = a_r1 < a_r2 ? a_r1 : a_r2;
    b_cmd.rhi      = a_r1 < a_r2 ? a_r2 : a_r1;
    b_cmd.clo      = a_c1 < a_c2 ? a_c1 : a_c2;
    b_cmd.chi      = a_c1 < a_c2 ? a_c2 : a_c1;
    b_cmd.glyph    = a_glyph;
    b_cmd.r1sq     = a_r1sq;
    b_cmd.c1sq     = a_c1sq;
    b_cmd.hi       = 17'(a_radsq) + 17'(a_rad);
    b_cmd.lo       = a_radsq - 16'(a_rad) + 16'd1;
    b_cmd.rad_zero = a_rad == 8'd0;
    b_cmd.dd       = a_dd;
    b_cmd.ee       = a_ee;
    b_cmd.n0       = 21'(a_c1dd) - 21'(a_r1ee);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (move) begin
      a_valid <= 1'b0;
    end
    if (accept) begin
      a_kind  <= kind_t'(kind);
      a_r1    <= first_row;
      a_c1    <= first_col;
      a_r2    <= second_row;
      a_c2    <= second_col;
      a_rad   <= radius;
      a_glyph <= glyph;
      a_dd    <= dd_s[7:0];
      a_ee    <= ee;
      a_r1sq  <= r1sq_s[15:0];
      a_c1sq  <= c1sq_s[15:0];
      a_radsq <= 16'(radius) * 16'(radius);
      a_c1dd  <= 17'(first_col) * 17'(dd_s);
      a_r1ee  <= 17'(first_row) * 17'(ee);
    end
  end

  assign cmd_valid = q_cnt != 2'd0;
  assign cmd       = q_mem[q_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp  <= 1'b0;
      q_rp  <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (move) begin
        q_wp <= ~q_wp;
      end
      if (cmd_take) begin
        q_rp <= ~q_rp;
      end
      q_cnt <= q_cnt + 2'(move) - 2'(cmd_take);
    end
    if (move) begin
      q_mem[q_wp] <= b_cmd;
    end
  end
endmodule

// ===== src/fsr_back.sv =====
// Back end: scans the canvas, writes the cell store and forms results.
module fsr_back import fsr_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  input  logic [6:0] rows,
  input  logic [6:0] cols,
  input  logic       res_ready,
  output logic       res_push,
  output logic [7:0] res_value,
  output logic       res_off,
  output logic       clearing
);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 8;

  typedef enum logic [2:0] {S_CLEAR_MEM, S_IDLE, S_SCAN, S_READ, S_DONE} state_t;

  state_t             state;
  cmd_t               c;
  logic [6:0]         i, j;
  logic [AW-1:0]      base, clr_addr;
  logic signed [9:0]  di, dj;
  logic [15:0]        di2, dj2;
  logic signed [20:0] n;
  logic [14:0]        jd;

  logic               we;
  logic [AW-1:0]      waddr, pt_addr;
  logic [7:0]         wdata, rdata;
  logic [PW-1:0]      pt_wide;
  logic               in_canvas, is_pt, hit;
  logic signed [9:0]  iw, jw, r1x, c1x, r2x, c2x, rlox, rhix, clox, chix;
  logic [16:0]        d2;
  logic [15:0]        jd_plus;
  logic signed [17:0] di2_step, dj2_step;
  logic               row_ok, line_hit;

  assign is_pt     = cmd.kind == K_POINT || cmd.kind == K_READ;
  assign in_canvas = !cmd.r1[7] && !cmd.c1[7] && cmd.r1[6:0] < rows && cmd.c1[6:0] < cols;
  assign pt_wide   = PW'(cmd.r1[6:0]) * PW'(MAX_COLS) + PW'(cmd.c1[6:0]);
  assign pt_addr   = pt_wide[AW-1:0];

  assign iw   = $signed({3'b0, i});
  assign jw   = $signed({3'b0, j});
  assign r1x  = 10'(c.r1);
  assign c1x  = 10'(c.c1);
  assign r2x  = 10'(c.r2);
  assign c2x  = 10'(c.c2);
  assign rlox = 10'(c.rlo);
  assign rhix = 10'(c.rhi);
  assign clox = 10'(c.clo);
  assign chix = 10'(c.chi);
  assign d2   = 17'(di2) + 17'(dj2);
  assign jd_plus = 16'(jd) + 16'(c.dd);
  assign row_ok  = iw >= rlox && iw <= rhix;

  always_comb begin
    if (c.r1 == c.r2) begin
      line_hit = jw >= clox && jw <= chix;
    end else if (n >= 0) begin
      line_hit = $signed({6'b0, jd}) <= n && n < $signed({5'b0, jd_plus});
    end else begin
      line_hit = j == 7'd0 && n > -$signed({13'b0, c.dd});
    end
  end

  always_comb begin
    case (c.kind)
      K_CLEAR:  hit = 1'b1;
      K_CIRCLE: hit = c.rad_zero ? d2 == 17'd0 : (d2 >= 17'(c.lo) && d2 <= c.hi);
      K_DISC:   hit = d2 <= c.hi;
      K_RECT:   hit = ((iw == r1x || iw == r2x) && jw >= clox && jw <= chix) ||
                      ((jw == c1x || jw == c2x) && row_ok);
      K_BOX:    hit = row_ok && jw >= c1x && jw <= c2x;
      K_LINE:   hit = row_ok && line_hit;
      default:  hit = 1'b0;
    endcase
  end

  assign di2_step = $signed({2'b0, di2}) + 18'(di) + 18'(di) + 18'sd1;
  assign dj2_step = $signed({2'b0, dj2}) + 18'(dj) + 18'(dj) + 18'sd1;

  always_comb begin
    we    = 1'b0;
    waddr = pt_addr;
    wdata = cmd.glyph;
    case (state)
      S_CLEAR_MEM: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = SPACE;
      end
      S_IDLE: begin
        we = cmd_valid && cmd.kind == K_POINT && in_canvas;
      end
      S_SCAN: begin
        we    = hit;
        waddr = base + AW'(j);
        wdata = c.kind == K_CLEAR ? SPACE : c.glyph;
      end
      default: we = 1'b0;
    endcase
  end

  fsr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pt_addr),
    .rdata (rdata)
  );

  assign cmd_take = state == S_IDLE && cmd_valid;
  assign res_push = state == S_DONE && res_ready;
  assign clearing = state == S_CLEAR_MEM;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR_MEM;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR_MEM: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c         <= cmd;
            res_value <= 8'd0;
            res_off   <= is_pt && !in_canvas;
            if (is_pt) begin
              if (!in_canvas) begin
                state <= S_DONE;
              end else if (cmd.kind == K_READ) begin
                state <= S_READ;
              end else begin
                state <= S_DONE;
              end
            end else if (rows == 7'd0 || cols == 7'd0) begin
              state <= S_DONE;
            end else begin
              i     <= '0;
              j     <= '0;
              base  <= '0;
              di    <= -10'(cmd.r1);
              dj    <= -10'(cmd.c1);
              di2   <= cmd.r1sq;
              dj2   <= cmd.c1sq;
              n     <= cmd.n0;
              jd    <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (j == cols - 7'd1) begin
            j    <= '0;
            dj   <= -c1x;
            dj2  <= c.c1sq;
            jd   <= '0;
            i    <= i + 7'd1;
            base <= base + AW'(MAX_COLS);
            di   <= di + 10'sd1;
            di2  <= di2_step[15:0];
            n    <= n + 21'(c.ee);
            if (i == rows - 7'd1) begin
              state <= S_DONE;
            end
          end else begin
            j   <= j + 7'd1;
            dj  <= dj + 10'sd1;
            dj2 <= dj2_step[15:0];
            jd  <= jd + 15'(c.dd);
          end
        end
        S_READ: begin
          res_value <= rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_in_canvas: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (i < rows && j < cols)) else $error("scan outside canvas");
  a_reset_clears: assert property (@(posedge clk)
    rst |=> state == S_CLEAR_MEM) else $error("no clearing pass after reset");
  a_read_after_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> $past(state) == S_IDLE) else $error("read without command");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !clearing && !res_push) else $error("command taken while busy");
endmodule

// ===== src/framebuffer_shape_rasterizer.sv =====
// Top level of the character frame buffer shape rasterizer.
// Usage:
//   Input channel: push with full; an item is taken when push is high and full
//   is low. Each item is one command (clear, point, circles, rectangles, line,
//   read). Output channel: empty with pop; the oldest result sits on read_value
//   and off_canvas while empty is low and is taken when pop is high.
//   Config: write_enable, reg_index, write_data; index 0 is the canvas width,
//   index 1 the canvas height. Write only while the block is idle.
// Timing:
//   A shape or clear command scans the canvas one cell per cycle through the
//   single write port of the cell store. A read takes its value through the
//   registered store read. Up to three items queue in front of the scanner.
// Reset: the store is swept to spaces with full held high; width and
//   height return to 64.
// Stall: with a result waiting and pop low the scanner holds after its
//   current command, and the front queue fills until full rises.
module framebuffer_shape_rasterizer import fsr_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        kind,
  input  logic signed [7:0] first_row,
  input  logic signed [7:0] first_col,
  input  logic signed [7:0] second_row,
  input  logic signed [7:0] second_col,
  input  logic [7:0]        radius,
  input  logic [7:0]        glyph,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        read_value,
  output logic              off_canvas,
  input  logic              write_enable,
  input  logic [0:0]        reg_index,
  input  logic [6:0]        write_data
);
  logic [6:0] canvas_width, canvas_height, rows, cols;
  logic       front_full, cmd_valid, cmd_take, clearing;
  logic       res_ready, res_push, res_off, out_valid;
  logic [7:0] res_value;
  cmd_t       cmd;

  assign rows = 11'(canvas_height) > 11'(MAX_ROWS) ? 7'(MAX_ROWS) : canvas_height;
  assign cols = 11'(canvas_width) > 11'(MAX_COLS) ? 7'(MAX_COLS) : canvas_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= 7'd64;
      canvas_height <= 7'd64;
    end else if (write_enable) begin
      case (reg_index)
        REG_WIDTH:  canvas_width  <= write_data;
        REG_HEIGHT: canvas_height <= write_data;
        default:    canvas_width  <= canvas_width;
      endcase
    end
  end

  assign full = front_full || clearing;

  fsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push && !clearing),
    .full       (front_full),
    .kind       (kind),
    .first_row  (first_row),
    .first_col  (first_col),
    .second_row (second_row),
    .second_col (second_col),
    .radius     (radius),
    .glyph      (glyph),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  fsr_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .rows      (rows),
    .cols      (cols),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res_value (res_value),
    .res_off   (res_off),
    .clearing  (clearing)
  );

  assign empty     = !out_valid;
  assign res_ready = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
    if (res_push) begin
      read_value <= res_value;
      off_canvas <= res_off;
    end
  end
endmodule

// ===== sim/framebuffer_shape_rasterizer_check.sv =====
// Checker for the frame buffer rasterizer: tracks the cell store and compares results.
`timescale 1ns / 100ps
module framebuffer_shape_rasterizer_check import fsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic [2:0]        kind,
  input  logic signed [7:0] first_row,
  input  logic signed [7:0] first_col,
  input  logic signed [7:0] second_row,
  input  logic signed [7:0] second_col,
  input  logic [7:0]        radius,
  input  logic [7:0]        glyph,
  input  logic              empty,
  input  logic              pop,
  input  logic [7:0]        read_value,
  input  logic              off_canvas,
  input  logic              write_enable,
  input  logic [0:0]        reg_index,
  input  logic [6:0]        write_data,
  output int                mismatches,
  output int                outstanding,
  output int                results_seen
);

  typedef struct {
    logic [7:0] read_value;
    logic       off_canvas;
  } pixel_result_t;

  logic [7:0]    cells [0:4095];
  logic [6:0]    canvas_w, canvas_h;
  pixel_result_t pending_results [$];

  assign outstanding = pending_results.size();

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic bit cell_drawn(input kind_t k, input int i, input int j, input int r1,
                                    input int c1, input int r2, input int c2,
                                    input longint rad);
    longint d2, hi, dr, dc, num;
    int rlo, rhi, clo, chi;
    d2  = longint'(i - r1) * (i - r1) + longint'(j - c1) * (j - c1);
    hi  = rad * rad + rad;
    rlo = r1 < r2 ? r1 : r2;
    rhi = r1 < r2 ? r2 : r1;
    clo = c1 < c2 ? c1 : c2;
    chi = c1 < c2 ? c2 : c1;
    case (k)
      K_CLEAR:  return 1;
      K_CIRCLE: return rad == 0 ? d2 == 0 : (d2 >= rad * rad - rad + 1 && d2 <= hi);
      K_DISC:   return d2 <= hi;
      K_RECT:   return ((i == r1 || i == r2) && j >= clo && j <= chi) ||
                       ((j == c1 || j == c2) && i >= rlo && i <= rhi);
      K_BOX:    return i >= rlo && i <= rhi && j >= c1 && j <= c2;
      K_LINE: begin
        if (i < rlo || i > rhi) return 0;
        if (r1 == r2) return j >= clo && j <= chi;
        dr  = r2 - r1;
        dc  = c2 - c1;
        num = longint'(c1) * dr + longint'(i - r1) * dc;
        return longint'(j) == num / dr;
      end
      default:  return 0;
    endcase
  endfunction

  task automatic rasterize_command();
    kind_t         k;
    int            rows, cols, r1, c1;
    logic [7:0]    fill;
    pixel_result_t res;
    k    = kind_t'(kind);
    rows = canvas_h > 64 ? 64 : canvas_h;
    cols = canvas_w > 64 ? 64 : canvas_w;
    r1   = first_row;
    c1   = first_col;
    res.read_value = 0;
    res.off_canvas = 0;
    if (k == K_POINT || k == K_READ) begin
      if (r1 < 0 || c1 < 0 || r1 >= rows || c1 >= cols) res.off_canvas = 1;
      else if (k == K_POINT) cells[r1 * 64 + c1] = glyph;
      else res.read_value = cells[r1 * 64 + c1];
    end else begin
      fill = k == K_CLEAR ? SPACE : glyph;
      for (int i = 0; i < rows; i++)
        for (int j = 0; j < cols; j++)
          if (cell_drawn(k, i, j, r1, c1, second_row, second_col, radius))
            cells[i * 64 + j] = fill;
    end
    pending_results.push_back(res);
  endtask

  initial begin
    mismatches   = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      foreach (cells[n]) cells[n] = SPACE;
      canvas_w = 64;
      canvas_h = 64;
    end else begin
      if (write_enable) begin
        if (reg_index == REG_WIDTH) canvas_w = write_data;
        else canvas_h = write_data;
      end
      if (push && !full) rasterize_command();
      if (pop && !empty) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          if (read_value !== pending_results[0].read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d", read_value,
                                      pending_results[0].read_value));
          if (off_canvas !== pending_results[0].off_canvas)
            report_mismatch($sformatf("off_canvas %0b, expected %0b", off_canvas,
                                      pending_results[0].off_canvas));
          void'(pending_results.pop_front());
        end
      end
    end
  end

endmodule

// ===== sim/framebuffer_shape_rasterizer_test.sv =====
// Testbench top: drives commands and canvas settings into the rasterizer.
`timescale 1ns / 100ps
module framebuffer_shape_rasterizer_test;
  import fsr_pkg::*;

  logic              clk = 0;
  logic              rst = 1;
  logic              push = 0;
  logic              full, empty, off_canvas;
  logic [2:0]        kind = K_CLEAR;
  logic signed [7:0] first_row = 0, first_col = 0, second_row = 0, second_col = 0;
  logic [7:0]        radius = 0, glyph = 0, read_value;
  logic              pop = 0;
  logic              write_enable = 0;
  logic [0:0]        reg_index = REG_WIDTH;
  logic [6:0]        write_data = 0;
  int                mismatches, outstanding, results_seen;
  int                commands_sent = 0, settings_used = 0;
  bit                steady = 0;

  framebuffer_shape_rasterizer i_dut (.*);
  framebuffer_shape_rasterizer_check i_check (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(negedge clk) pop <= steady || $urandom_range(0, 99) >= 12;

  task automatic send_command(input kind_t k, input int r1, input int c1, input int r2,
                              input int c2, input int rad, input int g);
    if (!steady && $urandom_range(0, 99) < 12) begin
      @(negedge clk) push <= 0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    push       <= 1;
    kind       <= k;
    first_row  <= 8'(r1);
    first_col  <= 8'(c1);
    second_row <= 8'(r2);
    second_col <= 8'(c2);
    radius     <= 8'(rad);
    glyph      <= 8'(g);
    do @(posedge clk); while (full);
    commands_sent++;
  endtask

  task automatic settle();
    @(negedge clk) push <= 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_canvas(input int w, input int h);
    settle();
    @(negedge clk);
    write_enable <= 1;
    reg_index    <= REG_WIDTH;
    write_data   <= 7'(w);
    @(negedge clk);
    reg_index    <= REG_HEIGHT;
    write_data   <= 7'(h);
    @(negedge clk) write_enable <= 0;
    settings_used++;
  endtask

  function automatic int near_coord(input int span);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, span + 7) - 4;
    return $signed(8'($urandom));
  endfunction

  task automatic random_command(input int w, input int h);
    kind_t k;
    int    span, rad;
    span = (w > h ? w : h) > 64 ? 64 : (w > h ? w : h);
    k    = $urandom_range(0, 99) < 40 ? K_READ : kind_t'($urandom_range(0, 6));
    rad  = $urandom_range(0, 99) < 85 ? $urandom_range(0, span / 2 + 2) : $urandom_range(0, 255);
    send_command(k, near_coord(span), near_coord(span), near_coord(span), near_coord(span),
                 rad, $urandom_range(0, 255));
  endtask

  int phase_w [7] = '{8, 1, 127, 5, 0, 13, 64};
  int phase_h [7] = '{8, 1, 3, 127, 0, 7, 64};

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 0;
    // Directed commands on the full canvas.
    send_command(K_POINT, 0, 0, 0, 0, 0, 8'hA5);
    send_command(K_POINT, 63, 63, 0, 0, 0, 8'h5A);
    send_command(K_POINT, -128, 127, 0, 0, 0, 8'hFF);
    send_command(K_POINT, 64, 0, 0, 0, 0, 8'h01);
    send_command(K_READ, 0, 0, 0, 0, 0, 0);
    send_command(K_READ, 63, 63, 0, 0, 0, 0);
    send_command(K_READ, 127, -128, 0, 0, 0, 0);
    send_command(K_CIRCLE, 10, 10, 0, 0, 0, 8'h2A);
    send_command(K_CIRCLE, 20, 20, 0, 0, 5, 8'h6F);
    send_command(K_DISC, 40, 40, 0, 0, 3, 8'h23);
    send_command(K_RECT, 30, 50, 5, 2, 0, 8'h7C);
    send_command(K_BOX, 60, 10, 50, 2, 0, 8'h58);
    send_command(K_BOX, 2, -128, 8, 127, 0, 8'h2D);
    send_command(K_LINE, 45, 70, 45, -3, 0, 8'h3D);
    send_command(K_LINE, -10, 33, 100, 33, 0, 8'h49);
    send_command(K_LINE, 60, 0, 3, 61, 0, 8'h2F);
    send_command(K_LINE, 0, 5, 63, 9, 0, 8'h5C);
    send_command(K_READ, 20, 25, 0, 0, 0, 0);
    send_command(K_READ, 45, 10, 0, 0, 0, 0);
    send_command(K_CLEAR, 0, 0, 0, 0, 0, 8'h00);
    send_command(K_READ, 63, 63, 0, 0, 0, 0);
    send_command(K_DISC, 0, 0, 0, 0, 255, 8'h80);
    send_command(K_READ, 33, 17, 0, 0, 0, 0);
    for (int p = 0; p < 7; p++) begin
      set_canvas(phase_w[p], phase_h[p]);
      steady = p == 2;
      for (int n = 0; n < (p == 6 ? 8 : 18); n++) random_command(phase_w[p], phase_h[p]);
    end
    steady = 0;
    settle();
    $display("covered %0d commands and %0d results over %0d canvas settings",
             commands_sent, results_seen, settings_used);
    $display("settings included empty, single-cell and clamped canvases");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fsr_pkg.sv
src/fsr_ram.sv
src/fsr_front.sv
src/fsr_back.sv
src/framebuffer_shape_rasterizer.sv
sim/framebuffer_shape_rasterizer_check.sv
sim/framebuffer_shape_rasterizer_test.sv
